// File: rtl/nmgll_pkg.sv
// Package for the GLL position parser: phase codes, ASCII codes, field sizes
// and the decimal place-value table. Used by every module under rtl/.
`default_nettype none

package nmgll_pkg;

  localparam int unsigned LAT_INT_DIGITS = 4;
  localparam int unsigned LON_INT_DIGITS = 5;
  localparam int unsigned FRAC_DIGITS    = 5;

  localparam int unsigned LAT_LEN = LAT_INT_DIGITS + FRAC_DIGITS;
  localparam int unsigned LON_LEN = LON_INT_DIGITS + FRAC_DIGITS;

  localparam int unsigned LAT_W  = 30;
  localparam int unsigned LON_W  = 34;
  localparam int unsigned CNT_W  = 4;
  localparam int unsigned BYTE_W = 8;

  localparam logic [LAT_W-1:0] LAT_MAX = LAT_W'(999999999);

  localparam logic [BYTE_W-1:0] ASCII_ZERO   = 8'd48;
  localparam logic [BYTE_W-1:0] ASCII_NINE   = 8'd57;
  localparam logic [BYTE_W-1:0] ASCII_DOLLAR = 8'h24;
  localparam logic [BYTE_W-1:0] ASCII_G      = 8'h47;
  localparam logic [BYTE_W-1:0] ASCII_P      = 8'h50;
  localparam logic [BYTE_W-1:0] ASCII_L      = 8'h4C;
  localparam logic [BYTE_W-1:0] ASCII_COMMA  = 8'h2C;
  localparam logic [BYTE_W-1:0] ASCII_N      = 8'h4E;

  typedef enum logic [10:0] {
    PH_HUNT = 11'b000_0000_0001,
    PH_HDR1 = 11'b000_0000_0010,
    PH_HDR2 = 11'b000_0000_0100,
    PH_HDR3 = 11'b000_0000_1000,
    PH_HDR4 = 11'b000_0001_0000,
    PH_HDR5 = 11'b000_0010_0000,
    PH_HDR6 = 11'b000_0100_0000,
    PH_LAT  = 11'b000_1000_0000,
    PH_HEMI = 11'b001_0000_0000,
    PH_SEP  = 11'b010_0000_0000,
    PH_LON  = 11'b100_0000_0000
  } phase_e;

  typedef struct packed {
    logic [LON_W-1:0] longitude_fixed;
    logic [LAT_W-1:0] latitude_fixed;
  } position_t;

  // Place value of a digit position counted from the least significant end.
  function automatic logic [LON_W-1:0] pow10(input logic [CNT_W-1:0] idx);
    logic [LON_W-1:0] val;
    case (idx)
      4'd0:    val = LON_W'(1);
      4'd1:    val = LON_W'(10);
      4'd2:    val = LON_W'(100);
      4'd3:    val = LON_W'(1000);
      4'd4:    val = LON_W'(10000);
      4'd5:    val = LON_W'(100000);
      4'd6:    val = LON_W'(1000000);
      4'd7:    val = LON_W'(10000000);
      4'd8:    val = LON_W'(100000000);
      4'd9:    val = LON_W'(1000000000);
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

`default_nettype wire

// File: rtl/nmgll_in_stage.sv
// Input register for the received byte stream.
// Depends on nmgll_pkg for the byte width.
`default_nettype none

module nmgll_in_stage (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         valid_i,
  output logic                              ready_o,
  input  wire logic [nmgll_pkg::BYTE_W-1:0] byte_i,
  output logic                              valid_o,
  input  wire logic                         take_i,
  output logic [nmgll_pkg::BYTE_W-1:0]      byte_o
);
  import nmgll_pkg::*;

  logic              valid_q, valid_d;
  logic [BYTE_W-1:0] byte_q;

  // Refill in the same cycle the held byte moves on.
  assign ready_o = !valid_q || take_i;
  assign valid_d = (valid_i && ready_o) || (valid_q && !take_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      byte_q <= byte_i;
    end
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;

endmodule

`default_nettype wire

// File: rtl/nmgll_parse.sv
// Sentence parser: header match, field digit accumulation and result forming.
// Depends on nmgll_pkg for phase codes, ASCII codes and the place-value table.
`default_nettype none

module nmgll_parse (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         fire_i,
  input  wire logic [nmgll_pkg::BYTE_W-1:0] byte_i,
  output logic                              res_valid_o,
  output nmgll_pkg::position_t              res_o
);
  import nmgll_pkg::*;

  phase_e           phase_q, phase_d;
  logic [LAT_W-1:0] lat_q, lat_d;
  logic [LON_W-1:0] lon_q, lon_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  logic              is_digit;
  logic              is_comma;
  logic [3:0]        digit;
  logic [CNT_W-1:0]  field_len;
  logic [CNT_W-1:0]  place_idx;
  logic              room;
  logic [LON_W+3:0]  term_full;
  logic [LON_W-1:0]  term;

  assign is_digit  = byte_i inside {[ASCII_ZERO:ASCII_NINE]};
  assign is_comma  = (byte_i == ASCII_COMMA);
  assign digit     = 4'(byte_i - ASCII_ZERO);
  assign field_len = (phase_q == PH_LAT) ? CNT_W'(LAT_LEN) : CNT_W'(LON_LEN);
  assign room      = (cnt_q < field_len);
  // Weight each digit by its final place so the trailing zero padding is implicit.
  assign place_idx = field_len - cnt_q - CNT_W'(1);
  assign term_full = digit * pow10(place_idx);
  assign term      = term_full[LON_W-1:0];

  always_comb begin
    phase_d = phase_q;
    lat_d   = lat_q;
    lon_d   = lon_q;
    cnt_d   = cnt_q;
    case (phase_q)
      PH_HUNT: phase_d = (byte_i == ASCII_DOLLAR) ? PH_HDR1 : PH_HUNT;
      PH_HDR1: phase_d = (byte_i == ASCII_G) ? PH_HDR2 : PH_HUNT;
      PH_HDR2: phase_d = (byte_i == ASCII_P) ? PH_HDR3 : PH_HUNT;
      PH_HDR3: phase_d = (byte_i == ASCII_G) ? PH_HDR4 : PH_HUNT;
      PH_HDR4: phase_d = (byte_i == ASCII_L) ? PH_HDR5 : PH_HUNT;
      PH_HDR5: phase_d = (byte_i == ASCII_L) ? PH_HDR6 : PH_HUNT;
      PH_HDR6: begin
        if (is_comma) begin
          phase_d = PH_LAT;
          lat_d   = '0;
          lon_d   = '0;
          cnt_d   = '0;
        end else begin
          phase_d = PH_HUNT;
        end
      end
      PH_LAT: begin
        if (is_comma) begin
          phase_d = PH_HEMI;
          cnt_d   = '0;
        end else if (is_digit && room) begin
          lat_d = lat_q + term[LAT_W-1:0];
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      PH_HEMI: phase_d = (byte_i == ASCII_N) ? PH_SEP : PH_HUNT;
      PH_SEP: begin
        if (is_comma) begin
          phase_d = PH_LON;
          lon_d   = '0;
          cnt_d   = '0;
        end else begin
          phase_d = PH_HUNT;
        end
      end
      PH_LON: begin
        if (is_comma) begin
          phase_d = PH_HUNT;
          cnt_d   = '0;
        end else if (is_digit && room) begin
          lon_d = lon_q + term;
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      default: phase_d = PH_HUNT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      lat_q   <= '0;
      lon_q   <= '0;
      cnt_q   <= '0;
    end else if (fire_i) begin
      phase_q <= phase_d;
      lat_q   <= lat_d;
      lon_q   <= lon_d;
      cnt_q   <= cnt_d;
    end
  end

  assign res_valid_o           = fire_i && (phase_q == PH_LON) && is_comma;
  assign res_o.latitude_fixed  = lat_q;
  assign res_o.longitude_fixed = lon_q;

  a_hunt_after_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |=> (phase_q == PH_HUNT))
    else $error("parser did not return to the hunt after a result");

  a_lat_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_LAT) |-> (cnt_q <= CNT_W'(LAT_LEN)))
    else $error("latitude digit count beyond field length");

  a_lon_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_LON) |-> (cnt_q <= CNT_W'(LON_LEN)))
    else $error("longitude digit count beyond field length");

  a_lat_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    lat_q <= LAT_MAX)
    else $error("latitude accumulator out of range");

  a_hold_when_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fire_i |=> $stable(phase_q) && $stable(cnt_q))
    else $error("parser state moved without a byte");

endmodule

`default_nettype wire

// File: rtl/nmgll_out_reg.sv
// Result register that holds one position until the downstream side takes it.
// Depends on nmgll_pkg for the position record.
`default_nettype none

module nmgll_out_reg (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 load_i,
  input  wire nmgll_pkg::position_t res_i,
  output logic                      can_load_o,
  output logic                      valid_o,
  input  wire logic                 ready_i,
  output nmgll_pkg::position_t      res_o
);
  import nmgll_pkg::*;

  logic      valid_q, valid_d;
  position_t res_q;

  assign can_load_o = !valid_q || ready_i;
  assign valid_d    = load_i || (valid_q && !ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

`default_nettype wire

// File: rtl/nmea_gll_position_parser.sv
// GLL position parser, top level: takes one NMEA byte per transaction on the
// slave stream and delivers each parsed latitude/longitude pair on the master
// stream. It sustains one byte per clock while no result waits in the output
// register; a byte is registered in the input stage, parsed by the single-pass
// parse stage, and its result (if any) is registered in the output register.
// While a result waits in the output register, the input stalls until the
// master side takes it. Both values are unsigned, scaled by 1e5 (ddmm.mmmmm and
// dddmm.mmmmm); missing trailing digits count as zero, extra digits are dropped.
// Depends on nmgll_pkg, nmgll_in_stage, nmgll_parse and nmgll_out_reg.
`default_nettype none

module nmea_gll_position_parser (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [63:0]      m_axis_tdata    // [29:0] latitude_fixed, [63:30] longitude_fixed
);
  import nmgll_pkg::*;

  logic              in_valid;
  logic [BYTE_W-1:0] in_byte;
  logic              can_load;
  logic              fire;
  logic              res_valid;
  position_t         res;
  position_t         out_res;

  nmgll_in_stage u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .byte_i  (s_axis_tdata),
    .valid_o (in_valid),
    .take_i  (fire),
    .byte_o  (in_byte)
  );

  // Advance a byte only when a possible result has somewhere to go.
  assign fire = in_valid && can_load;

  nmgll_parse u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .byte_i      (in_byte),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  nmgll_out_reg u_out_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (res_valid),
    .res_i      (res),
    .can_load_o (can_load),
    .valid_o    (m_axis_tvalid),
    .ready_i    (m_axis_tready),
    .res_o      (out_res)
  );

  assign m_axis_tdata = {out_res.longitude_fixed, out_res.latitude_fixed};

endmodule

`default_nettype wire
